/* hw/rtl/fractal_escape_time_classifier_core_assert.svh */
// ---------------------------------------------------------------------------
// Escape-time classifier assertion macros
// Shared concurrent assertion forms for the classifier checkers.
// ---------------------------------------------------------------------------
`ifndef FRACTAL_ESCAPE_TIME_CLASSIFIER_CORE_ASSERT_SVH
`define FRACTAL_ESCAPE_TIME_CLASSIFIER_CORE_ASSERT_SVH

// same-cycle implication
`define FETC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("fetc assertion failed");

// next-cycle implication
`define FETC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("fetc assertion failed");

`endif

/* hw/rtl/fetc_pkg.sv */
// ---------------------------------------------------------------------------
// Escape-time classifier package
// Formats, register indexes, reset values and word types shared by the core.
// ---------------------------------------------------------------------------
package fetc_pkg;

	localparam int COORD_W = 32;           // z component width
	localparam int FRAC    = 26;           // fraction bits
	localparam int PT_W    = 30;           // point / c width
	localparam int JC_W    = 28;           // julia constant width
	localparam int CNT_W   = 8;            // iteration count width
	localparam int CLS_W   = 3;
	localparam int CFG_W   = 28;
	localparam int IDX_W   = 2;
	localparam int MUL_W   = FRAC + 3;     // holds +/-2.0
	localparam int SQ_W    = 2 * MUL_W;
	localparam int NW      = COORD_W + 2;  // update sum width

	localparam logic [IDX_W-1:0] REG_MODE = 2'd0;
	localparam logic [IDX_W-1:0] REG_CR   = 2'd1;
	localparam logic [IDX_W-1:0] REG_CI   = 2'd2;
	localparam logic [IDX_W-1:0] REG_MAX  = 2'd3;

	localparam logic                   MODE_RST = 1'b1;
	localparam logic signed [JC_W-1:0] JCR_RST  = -28'sd46976205;
	localparam logic signed [JC_W-1:0] JCI_RST  = 28'sd18129044;
	localparam logic [CNT_W-1:0]       MAX_RST  = 8'd42;

	typedef struct packed {
		logic signed [COORD_W-1:0] zr;
		logic signed [COORD_W-1:0] zi;
		logic signed [PT_W-1:0]    cr;
		logic signed [PT_W-1:0]    ci;
		logic [CNT_W-1:0]          cnt;
	} iter_t;

	typedef struct packed {
		logic             cont;
		logic             fin;
		logic [CNT_W-1:0] res;
		iter_t            w;
	} cell_out_t;

	// class from count mod 7, folded on 3-bit groups (8 = 1 mod 7)
	function automatic logic [CLS_W-1:0] color_of(input logic [CNT_W-1:0] x);
		logic [4:0] s1;
		logic [3:0] s2;
		logic [2:0] r;
		s1 = 5'(x[2:0]) + 5'(x[5:3]) + 5'(x[7:6]);
		s2 = 4'(s1[2:0]) + 4'(s1[4:3]);
		r  = (s2 >= 4'd7) ? 3'(s2 - 4'd7) : s2[2:0];
		if (x == '0) begin
			return 3'd0;
		end else if (r >= 3'd1 && r <= 3'd5) begin
			return r;
		end else begin
			return 3'd6;
		end
	endfunction

endpackage

/* hw/rtl/fractal_escape_time_classifier_core.sv */
// ---------------------------------------------------------------------------
// Fractal escape-time classifier core
// Julia / Mandelbrot escape count of one Q3.26 point per word, run on a
// ring of two iteration cells.
// ---------------------------------------------------------------------------
// Input channel: in_valid / in_stall carry point_real, point_imag. Output
// channel: out_valid / out_stall carry escape_count, inside_res, color_class.
// Registers are written on cfg_we with cfg_idx / cfg_data; the user
// must write them only while idle; the block itself does not enforce it.
// One point is in flight at a time. Each iteration passes through a
// cell's squares register, then its update register, and the point
// alternates between the cells. A point ends when it fails the radius
// test, overflows or hits the iteration limit. The next word is taken
// the cycle after the result enters the output register.
// in_stall is high from acceptance until the result is in the output
// register; a result that meets a full output register waits in a one-word
// hold with in_stall still high. A new point can start while a result waits
// on out_stall in the output register. Reset clears all valid state and
// loads the register defaults (Julia, c = -0.7 + 0.27014i, max_iter 42).
// ---------------------------------------------------------------------------
module fractal_escape_time_classifier_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [fetc_pkg::IDX_W-1:0]        cfg_idx,
	input  logic [fetc_pkg::CFG_W-1:0]        cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic signed [fetc_pkg::PT_W-1:0]  point_real,
	input  logic signed [fetc_pkg::PT_W-1:0]  point_imag,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [fetc_pkg::CNT_W-1:0]        escape_count,
	output logic                              inside_res,
	output logic [fetc_pkg::CLS_W-1:0]        color_class
);
	import fetc_pkg::*;

	logic                   mode_q;
	logic signed [JC_W-1:0] jcr_q, jci_q;
	logic [CNT_W-1:0]       max_q;

	logic                   busy_q, pend_q, out_valid_q;
	logic [CNT_W-1:0]       pend_res_q, cnt_q;
	logic [CLS_W-1:0]       class_q;

	logic                   acc, take, out_free, fin_any, load;
	logic [CNT_W-1:0]       fin_res, load_res;
	iter_t                  start_w, c0_in;
	logic                   c0_valid;
	cell_out_t              c0_out, c1_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_RST;
			jcr_q  <= JCR_RST;
			jci_q  <= JCI_RST;
			max_q  <= MAX_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_MODE: mode_q <= cfg_data[0];
				REG_CR:   jcr_q  <= cfg_data[JC_W-1:0];
				REG_CI:   jci_q  <= cfg_data[JC_W-1:0];
				REG_MAX:  max_q  <= cfg_data[CNT_W-1:0];
			endcase
		end
	end

	assign acc      = in_valid && !busy_q;
	assign take     = out_valid_q && !out_stall;
	assign out_free = !out_valid_q || take;
	assign fin_any  = c0_out.fin || c1_out.fin;
	assign fin_res  = c0_out.fin ? c0_out.res : c1_out.res;
	assign load     = out_free && (pend_q || fin_any);
	assign load_res = pend_q ? pend_res_q : fin_res;

	always_comb begin
		start_w.zr  = mode_q ? COORD_W'(point_real) : '0;
		start_w.zi  = mode_q ? COORD_W'(point_imag) : '0;
		start_w.cr  = mode_q ? PT_W'(jcr_q) : point_real;
		start_w.ci  = mode_q ? PT_W'(jci_q) : point_imag;
		start_w.cnt = '0;
	end

	assign c0_valid = acc || c1_out.cont;
	assign c0_in    = acc ? start_w : c1_out.w;

	fetc_cell u_cell0 (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (c0_valid),
		.in_word  (c0_in),
		.max_iter (max_q),
		.out      (c0_out)
	);

	fetc_cell u_cell1 (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (c0_out.cont),
		.in_word  (c0_out.w),
		.max_iter (max_q),
		.out      (c1_out)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (acc) begin
				busy_q <= 1'b1;
			end else if (load) begin
				busy_q <= 1'b0;
			end
			if (load) begin
				pend_q <= 1'b0;
			end else if (fin_any) begin
				pend_q <= 1'b1;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (take) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fin_any && !load) begin
			pend_res_q <= fin_res;
		end
		if (load) begin
			cnt_q   <= load_res;
			class_q <= color_of(load_res);
		end
	end

	assign in_stall     = busy_q;
	assign out_valid    = out_valid_q;
	assign escape_count = cnt_q;
	assign inside_res   = (cnt_q == '0);
	assign color_class  = class_q;

endmodule

/* hw/rtl/fetc_cell.sv */
// ---------------------------------------------------------------------------
// Escape-time iteration cell
// One z = z*z + c step: squares and cross product registered, then radius
// test, rescale, overflow check and limit check registered to the next cell.
// ---------------------------------------------------------------------------
module fetc_cell (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	input  fetc_pkg::iter_t          in_word,
	input  logic [fetc_pkg::CNT_W-1:0] max_iter,
	output fetc_pkg::cell_out_t      out
);
	import fetc_pkg::*;

	localparam logic signed [COORD_W-1:0] TWO     = COORD_W'(2) <<< FRAC;
	localparam logic signed [COORD_W-1:0] TWO_NEG = -TWO;
	localparam logic [SQ_W:0]             RAD_LIM = (SQ_W+1)'(1) << (2 * FRAC + 2);

	logic signed [MUL_W-1:0] ar, ai;
	logic                    mag_ok;

	logic                    valid_s1;
	logic signed [SQ_W-1:0]  prr_s1, pii_s1, pri_s1;
	logic                    mag_ok_s1;
	logic signed [PT_W-1:0]  cr_s1, ci_s1;
	logic [CNT_W-1:0]        cnt_s1;

	logic [SQ_W:0]           rad;
	logic signed [NW-1:0]    nr, ni;
	logic                    live, inr, ovf, fin, cont;
	logic [CNT_W-1:0]        nxt, fcnt;

	logic                    cont_s2, fin_s2;
	logic [CNT_W-1:0]        res_s2;
	iter_t                   w_s2;

	assign ar = in_word.zr[MUL_W-1:0];
	assign ai = in_word.zi[MUL_W-1:0];
	assign mag_ok = (in_word.zr <= TWO) && (in_word.zr >= TWO_NEG) &&
		(in_word.zi <= TWO) && (in_word.zi >= TWO_NEG);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		prr_s1    <= ar * ar;
		pii_s1    <= ai * ai;
		pri_s1    <= ar * ai;
		mag_ok_s1 <= mag_ok;
		cr_s1     <= in_word.cr;
		ci_s1     <= in_word.ci;
		cnt_s1    <= in_word.cnt;
	end

	assign rad = $unsigned((SQ_W+1)'(prr_s1)) + $unsigned((SQ_W+1)'(pii_s1));
	assign nr  = NW'(prr_s1 >>> FRAC) - NW'(pii_s1 >>> FRAC) + NW'(cr_s1);
	assign ni  = NW'(pri_s1 >>> (FRAC - 1)) + NW'(ci_s1);
	assign ovf = !((nr[NW-1:COORD_W-1] == '0) || (nr[NW-1:COORD_W-1] == '1)) ||
		!((ni[NW-1:COORD_W-1] == '0) || (ni[NW-1:COORD_W-1] == '1));
	assign live = cnt_s1 < max_iter;
	assign inr  = live && mag_ok_s1 && (rad <= RAD_LIM);
	assign nxt  = CNT_W'(cnt_s1 + CNT_W'(1));

	always_comb begin
		fin  = 1'b0;
		cont = 1'b0;
		fcnt = cnt_s1;
		priority if (!inr) begin
			fin = valid_s1;
		end else if (ovf || nxt == max_iter) begin
			fin  = valid_s1;
			fcnt = nxt;
		end else begin
			cont = valid_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cont_s2 <= 1'b0;
			fin_s2  <= 1'b0;
		end else begin
			cont_s2 <= cont;
			fin_s2  <= fin;
		end
	end

	always_ff @(posedge clk) begin
		res_s2   <= (fcnt == max_iter) ? '0 : fcnt;
		w_s2.zr  <= nr[COORD_W-1:0];
		w_s2.zi  <= ni[COORD_W-1:0];
		w_s2.cr  <= cr_s1;
		w_s2.ci  <= ci_s1;
		w_s2.cnt <= nxt;
	end

	assign out.cont = cont_s2;
	assign out.fin  = fin_s2;
	assign out.res  = res_s2;
	assign out.w    = w_s2;

endmodule

/* hw/rtl/fetc_checker.sv */
// ---------------------------------------------------------------------------
// Escape-time classifier port checker
// Port-level checks on the core, bound to the top level.
// ---------------------------------------------------------------------------
`include "fractal_escape_time_classifier_core_assert.svh"

module fetc_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_stall,
	input logic                         out_valid,
	input logic                         out_stall,
	input logic [fetc_pkg::CNT_W-1:0]   escape_count,
	input logic                         inside_res,
	input logic [fetc_pkg::CLS_W-1:0]   color_class
);
	import fetc_pkg::*;

	// out_valid holds while stalled
	`FETC_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid)
	// one point in flight: busy right after a point is taken
	`FETC_ASSERT_NXT(a_one_point, clk, arst_n, in_valid && !in_stall, in_stall)
	`FETC_ASSERT_IMP(a_inside, clk, arst_n, out_valid,
		inside_res == (escape_count == '0))
	`FETC_ASSERT_IMP(a_class, clk, arst_n, out_valid,
		(color_class == '0) == inside_res && color_class != 3'd7)

endmodule

bind fractal_escape_time_classifier_core fetc_checker u_fetc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.escape_count (escape_count),
	.inside_res   (inside_res),
	.color_class  (color_class)
);

/* bench/tb_fractal_escape_time_classifier_core.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Escape-time classifier core bench
// Feeds Q3.26 points through the core in Julia and Mandelbrot mode under a
// run of register settings, predicts each escape count, inside flag and
// colour class in the bench and checks every output word in order.
// ---------------------------------------------------------------------------
module tb_fractal_escape_time_classifier_core;
	import fetc_pkg::*;

	localparam int ONE = 1 << FRAC;
	localparam int QUIET_LIMIT = 4000;
	localparam int RAND_PHASES = 10;
	localparam int PHASE_POINTS = 133;
	localparam longint unsigned TWO_FX = 64'd1 << (FRAC + 1);
	localparam longint unsigned RADIUS_SQ = 64'd1 << (2 * FRAC + 2);
	localparam longint COORD_LIM = 64'sd1 <<< (COORD_W - 1);
	localparam logic signed [PT_W-1:0] PT_MAX = {1'b0, {(PT_W-1){1'b1}}};
	localparam logic signed [PT_W-1:0] PT_MIN = {1'b1, {(PT_W-1){1'b0}}};
	localparam logic [CFG_W-1:0] C_MAX = {1'b0, {(CFG_W-1){1'b1}}};
	localparam logic [CFG_W-1:0] C_MIN = {1'b1, {(CFG_W-1){1'b0}}};

	typedef struct {
		logic signed [PT_W-1:0] re;
		logic signed [PT_W-1:0] im;
	} point_t;

	typedef struct {
		logic [CNT_W-1:0] count;
		logic             in_set;
		logic [CLS_W-1:0] shade;
	} escape_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    cfg_we = 1'b0;
	logic [IDX_W-1:0]        cfg_idx = '0;
	logic [CFG_W-1:0]        cfg_data = '0;
	logic                    in_valid = 1'b0;
	logic                    in_stall;
	logic signed [PT_W-1:0]  point_real = '0;
	logic signed [PT_W-1:0]  point_imag = '0;
	logic                    out_valid;
	logic                    out_stall = 1'b0;
	logic [CNT_W-1:0]        escape_count;
	logic                    inside_res;
	logic [CLS_W-1:0]        color_class;

	// bench copy of the registers
	logic                    cfg_julia = MODE_RST;
	logic signed [JC_W-1:0]  cfg_cr = JCR_RST;
	logic signed [JC_W-1:0]  cfg_ci = JCI_RST;
	logic [CNT_W-1:0]        cfg_max = MAX_RST;

	point_t  queued_points[$];
	escape_t due_escapes[$];
	int      errors = 0;
	int      points_sent = 0;
	int      words_seen = 0;
	int      inside_seen = 0;
	int      settings_run = 1;
	bit      rx_stalls = 1'b1;

	fractal_escape_time_classifier_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_idx      (cfg_idx),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.point_real   (point_real),
		.point_imag   (point_imag),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.escape_count (escape_count),
		.inside_res   (inside_res),
		.color_class  (color_class)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic bit in_coord(input longint v);
		return v >= -COORD_LIM && v < COORD_LIM;
	endfunction

	// |z|^2 <= 4, exact
	function automatic bit in_disc(input longint zr, input longint zi);
		longint unsigned mr, mi;
		mr = (zr < 0) ? -zr : zr;
		mi = (zi < 0) ? -zi : zi;
		if (mr > TWO_FX || mi > TWO_FX) begin
			return 1'b0;
		end
		return (mr * mr + mi * mi) <= RADIUS_SQ;
	endfunction

	function automatic escape_t escape_of(input logic signed [PT_W-1:0] pr,
			input logic signed [PT_W-1:0] pi);
		longint  zr, zi, cr, ci, nr, ni;
		int      n, m;
		bit      alive;
		escape_t r;
		alive = 1'b1;
		if (cfg_julia) begin
			zr = longint'(pr);
			zi = longint'(pi);
			cr = longint'(cfg_cr);
			ci = longint'(cfg_ci);
			alive = in_coord(zr) && in_coord(zi);
		end else begin
			zr = 0;
			zi = 0;
			cr = longint'(pr);
			ci = longint'(pi);
		end
		n = 0;
		while (alive && n < int'(cfg_max)) begin
			if (!in_disc(zr, zi)) begin
				break;
			end
			nr = ((zr * zr) >>> FRAC) - ((zi * zi) >>> FRAC) + cr;
			ni = ((zr * zi) >>> (FRAC - 1)) + ci;
			n++;
			if (!in_coord(nr) || !in_coord(ni)) begin
				break;
			end
			zr = nr;
			zi = ni;
		end
		if (n == int'(cfg_max)) begin
			n = 0;
		end
		r.count = CNT_W'(n);
		r.in_set = (n == 0);
		if (n == 0) begin
			r.shade = '0;
		end else begin
			m = n % 7;
			r.shade = (m >= 1 && m <= 5) ? CLS_W'(m) : CLS_W'(6);
		end
		return r;
	endfunction

	function automatic logic signed [PT_W-1:0] rand_coord();
		int pick;
		int sgn;
		pick = $urandom_range(0, 9);
		sgn = ($urandom_range(0, 1) != 0) ? 1 : -1;
		case (pick)
			0: begin
				return PT_W'($urandom);
			end
			1: begin
				return PT_W'(int'($urandom_range(0, 512)) - 256);
			end
			2: begin
				return PT_W'(sgn * (2 * ONE + int'($urandom_range(0, 64)) - 32));
			end
			default: begin
				return PT_W'(int'($urandom_range(0, 5 * ONE)) - 5 * ONE / 2);
			end
		endcase
	endfunction

	function automatic logic [CFG_W-1:0] rand_const();
		return CFG_W'(int'($urandom_range(0, 2 * ONE)) - ONE);
	endfunction

	task automatic report_err(input string what);
		$display("ERROR %0t: %s", $time, what);
		errors++;
	endtask

	task automatic add_point(input logic signed [PT_W-1:0] re,
			input logic signed [PT_W-1:0] im);
		point_t p;
		p.re = re;
		p.im = im;
		queued_points.push_back(p);
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		case (idx)
			REG_MODE: cfg_julia = val[0];
			REG_CR:   cfg_cr = val[JC_W-1:0];
			REG_CI:   cfg_ci = val[JC_W-1:0];
			REG_MAX:  cfg_max = val[CNT_W-1:0];
			default: ;
		endcase
	endtask

	task automatic set_regs(input logic mode, input logic [CFG_W-1:0] cr,
			input logic [CFG_W-1:0] ci, input logic [CNT_W-1:0] lim);
		write_reg(REG_MODE, CFG_W'(mode));
		write_reg(REG_CR, cr);
		write_reg(REG_CI, ci);
		write_reg(REG_MAX, CFG_W'(lim));
		@(posedge clk);
		cfg_we <= 1'b0;
		settings_run++;
	endtask

	task automatic wait_idle();
		do begin
			@(negedge clk);
		end while (queued_points.size() != 0 || in_valid || due_escapes.size() != 0);
		repeat (6) @(negedge clk);
	endtask

	// sender: bursts of words with random gaps
	always @(posedge clk or negedge arst_n) begin : drive
		int     burst_left;
		int     gap_left;
		bit     took;
		point_t p;
		if (!arst_n) begin
			in_valid <= 1'b0;
			burst_left = 0;
			gap_left = 0;
		end else begin
			took = in_valid && !in_stall;
			if (took) begin
				due_escapes.push_back(escape_of(point_real, point_imag));
				points_sent++;
			end
			if (!in_valid || took) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (queued_points.size() > 0) begin
					p = queued_points.pop_front();
					point_real <= p.re;
					point_imag <= p.im;
					in_valid <= 1'b1;
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 8);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver: checks each word, stalls in runs
	always @(posedge clk or negedge arst_n) begin : observe
		int      stall_run;
		escape_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_run = 0;
		end else begin
			if (out_valid && !out_stall) begin
				words_seen++;
				if (inside_res === 1'b1) begin
					inside_seen++;
				end
				if (due_escapes.size() == 0) begin
					report_err("output word with no point outstanding");
				end else begin
					want = due_escapes.pop_front();
					if (escape_count !== want.count) begin
						report_err($sformatf("escape_count %0d, want %0d",
							escape_count, want.count));
					end
					if (inside_res !== want.in_set) begin
						report_err($sformatf("inside_res %b, want %b",
							inside_res, want.in_set));
					end
					if (color_class !== want.shade) begin
						report_err($sformatf("color_class %0d, want %0d",
							color_class, want.shade));
					end
				end
			end
			if (stall_run > 0) begin
				stall_run--;
			end else if (out_stall || !rx_stalls) begin
				out_stall <= 1'b0;
				stall_run = $urandom_range(1, 24);
			end else begin
				out_stall <= 1'b1;
				stall_run = $urandom_range(1, 10);
			end
		end
	end

	always @(posedge clk) begin : watchdog
		int quiet;
		if (!arst_n) begin
			quiet = 0;
		end else if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet = 0;
		end else begin
			quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("TIMEOUT: no word moved for %0d cycles", QUIET_LIMIT);
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	initial begin : stimulus
		int ph;
		int k;
		logic [CNT_W-1:0] lim;
		logic [CFG_W-1:0] cr, ci;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Julia at reset values: edges of the disc and of the format
		add_point('0, '0);
		add_point(PT_W'(2 * ONE), '0);
		add_point(PT_W'(2 * ONE + 1), '0);
		add_point('0, PT_W'(-2 * ONE));
		add_point('0, PT_W'(-2 * ONE - 1));
		add_point(PT_MAX, PT_MAX);
		add_point(PT_MIN, PT_MIN);
		add_point(PT_MAX, PT_MIN);
		add_point(PT_MIN, PT_MAX);
		add_point(PT_W'(ONE), PT_W'(ONE));
		add_point(PT_W'(-ONE / 2), PT_W'(ONE / 4));
		add_point(PT_W'(1), PT_W'(-1));
		add_point(PT_W'(-1), PT_W'(1));
		wait_idle();

		// Mandelbrot, default limit
		set_regs(1'b0, JCR_RST, JCI_RST, MAX_RST);
		add_point('0, '0);
		add_point(PT_W'(-2 * ONE), '0);
		add_point(PT_W'(ONE / 4), '0);
		add_point(PT_W'(ONE / 4 + 1), '0);
		add_point(PT_W'(ONE), PT_W'(ONE));
		add_point(PT_W'(-ONE), '0);
		add_point('0, PT_W'(ONE));
		add_point(PT_MAX, '0);
		add_point(PT_MIN, PT_MIN);
		add_point(PT_W'(-3 * ONE / 4), PT_W'(ONE / 8));
		add_point(PT_W'(ONE / 2), PT_W'(ONE / 2));
		wait_idle();

		for (ph = 0; ph < RAND_PHASES; ph++) begin
			case (ph)
				0: lim = 8'd1;
				1: lim = 8'd255;
				2: lim = 8'd2;
				6: lim = 8'd128;
				default: lim = CNT_W'($urandom_range(3, 64));
			endcase
			case (ph)
				3: begin
					cr = C_MIN;
					ci = C_MIN;
				end
				4: begin
					cr = C_MAX;
					ci = C_MAX;
				end
				5: begin
					cr = CFG_W'($urandom);
					ci = CFG_W'($urandom);
				end
				default: begin
					cr = rand_const();
					ci = rand_const();
				end
			endcase
			rx_stalls = (ph % 3 != 2);
			set_regs((ph % 2) != 0, cr, ci, lim);
			for (k = 0; k < PHASE_POINTS; k++) begin
				add_point(rand_coord(), rand_coord());
			end
			wait_idle();
		end

		repeat (20) @(negedge clk);
		$display("Ran %0d points under %0d register settings, Julia and Mandelbrot,",
			points_sent, settings_run);
		$display("limits 1 to 255; %0d words checked, %0d flagged inside.",
			words_seen, inside_seen);
		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
